// ===== hw/rtl/clx_pkg.sv =====
// Shared types, constants and keyword tables of the C token lexer.
package clx_pkg;

	// Width of the text offset counter
	localparam int IDX_W = 16;
	localparam int FIELD_W = 16;
	localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

	// Result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	// Stream payload widths
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 56;

	// Character codes
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_SLASH = "/";
	localparam logic [7:0] CH_UNDER = "_";
	localparam logic [7:0] CH_LBRACE = "{";
	localparam logic [7:0] CH_RBRACE = "}";
	localparam logic [7:0] CH_SEMI = ";";
	localparam logic [7:0] CH_STAR = "*";

	typedef enum logic [3:0] {
		KIND_EOF       = 4'd0,
		KIND_LBRACE    = 4'd1,
		KIND_RBRACE    = 4'd2,
		KIND_SEMI      = 4'd3,
		KIND_STAR      = 4'd4,
		KIND_NUMBER    = 4'd5,
		KIND_IDENT     = 4'd6,
		KIND_TYPEDEF   = 4'd7,
		KIND_KW_STRUCT = 4'd8,
		KIND_INT       = 4'd9,
		KIND_CHAR      = 4'd10,
		KIND_FLOAT     = 4'd11
	} kind_t;

	// Keyword spelling, one row per keyword in kind order
	localparam int NUM_KW = 5;
	localparam logic [0:NUM_KW-1][0:7][7:0] KW_TEXT = '{
		'{"t", "y", "p", "e", "d", "e", "f", 8'h00},
		'{"s", "t", "r", "u", "c", "t", 8'h00, 8'h00},
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00}
	};
	localparam logic [0:NUM_KW-1][2:0] KW_LEN = '{3'd7, 3'd6, 3'd3, 3'd4, 3'd5};

	// One emitted token
	typedef struct packed {
		kind_t              kind;
		logic [FIELD_W-1:0] start;
		logic [FIELD_W-1:0] length;
		logic [FIELD_W-1:0] line;
		logic               last;
	} tok_t;

	// Up to two tokens produced by one byte
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       tok0;
		tok_t       tok1;
	} push_t;

	// Clamp an offset to the 16-bit result field
	function automatic logic [FIELD_W-1:0] sat_field(input logic [IDX_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'(FIELD_MAX)) ? FIELD_MAX : w[FIELD_W-1:0];
	endfunction

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

endpackage

// ===== hw/rtl/clx_core.sv =====
// Lexer state and the per-byte token decision logic.
module clx_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     text_char,
	output clx_pkg::push_t push
);

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_NUM     = 3'd1,
		MODE_IDENT   = 3'd2,
		MODE_SLASH   = 3'd3,
		MODE_COMMENT = 3'd4
	} mode_t;

	mode_t                        mode_q, mode_d;
	logic [clx_pkg::IDX_W-1:0]    off_q, off_d;
	logic [clx_pkg::IDX_W-1:0]    begin_q, begin_d;
	logic [clx_pkg::FIELD_W-1:0]  line_q, line_d;
	logic [clx_pkg::FIELD_W-1:0]  bline_q, bline_d;
	logic [clx_pkg::NUM_KW-1:0]   kw_q, kw_d;

	clx_pkg::tok_t                res [2];
	logic [1:0]                   n;

	// One byte of lexing: pending token, end of text, comment, new token
	always_comb begin
		logic                       done;
		logic                       adv;
		logic [clx_pkg::IDX_W-1:0]  pos;
		clx_pkg::kind_t             pkind;
		mode_t                      eff;

		mode_d  = mode_q;
		off_d   = off_q;
		begin_d = begin_q;
		line_d  = line_q;
		bline_d = bline_q;
		kw_d    = kw_q;
		res[0]  = '0;
		res[1]  = '0;
		n       = 2'd0;
		done    = 1'b0;
		adv     = 1'b0;
		pos     = off_q - begin_q;
		pkind   = clx_pkg::KIND_NUMBER;
		eff     = mode_q;

		// Pending number or identifier
		if (mode_q == MODE_NUM || mode_q == MODE_IDENT) begin
			if (mode_q == MODE_NUM && clx_pkg::is_dec(text_char)) begin
				adv  = 1'b1;
				done = 1'b1;
			end else if (mode_q == MODE_IDENT && (clx_pkg::is_letter(text_char) ||
				clx_pkg::is_dec(text_char) || text_char == clx_pkg::CH_UNDER)) begin
				if (off_q == '1) begin
					kw_d = '0;
				end else begin
					for (int i = 0; i < clx_pkg::NUM_KW; i++) begin
						if (pos >= clx_pkg::IDX_W'(clx_pkg::KW_LEN[i]) ||
							clx_pkg::KW_TEXT[i][pos[2:0]] != text_char) begin
							kw_d[i] = 1'b0;
						end
					end
				end
				adv  = 1'b1;
				done = 1'b1;
			end else begin
				if (mode_q == MODE_IDENT) begin
					pkind = clx_pkg::KIND_IDENT;
					for (int i = 0; i < clx_pkg::NUM_KW; i++) begin
						if (kw_q[i] && pos == clx_pkg::IDX_W'(clx_pkg::KW_LEN[i])) begin
							pkind = clx_pkg::kind_t'(4'(clx_pkg::KIND_TYPEDEF) + 4'(i));
						end
					end
				end
				res[0].kind   = pkind;
				res[0].start  = clx_pkg::sat_field(begin_q);
				res[0].length = clx_pkg::sat_field(pos);
				res[0].line   = bline_q;
				n      = 2'd1;
				eff    = MODE_IDLE;
				mode_d = MODE_IDLE;
			end
		end

		// End of text: eof token and full reset
		if (!done && text_char == clx_pkg::CH_NUL) begin
			res[n[0]].kind   = clx_pkg::KIND_EOF;
			res[n[0]].start  = clx_pkg::sat_field(off_q);
			res[n[0]].length = '0;
			res[n[0]].line   = line_q;
			n       = n + 2'd1;
			mode_d  = MODE_IDLE;
			off_d   = '0;
			begin_d = '0;
			line_d  = 16'd1;
			bline_d = 16'd1;
			kw_d    = '0;
			done    = 1'b1;
		end

		// Slash and comment modes
		if (!done) begin
			if (eff == MODE_SLASH) begin
				mode_d = MODE_IDLE;
				if (text_char == clx_pkg::CH_SLASH) begin
					mode_d = MODE_COMMENT;
					adv    = 1'b1;
					done   = 1'b1;
				end
			end else if (eff == MODE_COMMENT) begin
				if (text_char == clx_pkg::CH_LF) begin
					if (line_q != '1) line_d = line_q + 16'd1;
					mode_d = MODE_IDLE;
				end
				adv  = 1'b1;
				done = 1'b1;
			end else begin
				mode_d = MODE_IDLE;
			end
		end

		// Start of a new token
		if (!done) begin
			adv = 1'b1;
			if (text_char == clx_pkg::CH_LBRACE || text_char == clx_pkg::CH_RBRACE ||
				text_char == clx_pkg::CH_SEMI || text_char == clx_pkg::CH_STAR) begin
				res[n[0]].kind = (text_char == clx_pkg::CH_LBRACE) ? clx_pkg::KIND_LBRACE :
					(text_char == clx_pkg::CH_RBRACE) ? clx_pkg::KIND_RBRACE :
					(text_char == clx_pkg::CH_SEMI) ? clx_pkg::KIND_SEMI : clx_pkg::KIND_STAR;
				res[n[0]].start  = clx_pkg::sat_field(off_q);
				res[n[0]].length = 16'd1;
				res[n[0]].line   = line_q;
				n = n + 2'd1;
			end else if (clx_pkg::is_dec(text_char)) begin
				mode_d  = MODE_NUM;
				begin_d = off_q;
				bline_d = line_q;
			end else if (clx_pkg::is_letter(text_char)) begin
				mode_d  = MODE_IDENT;
				begin_d = off_q;
				bline_d = line_q;
				for (int i = 0; i < clx_pkg::NUM_KW; i++) begin
					kw_d[i] = (clx_pkg::KW_TEXT[i][0] == text_char);
				end
			end else if (text_char == clx_pkg::CH_SLASH) begin
				mode_d = MODE_SLASH;
			end else if (text_char == clx_pkg::CH_LF) begin
				if (line_q != '1) line_d = line_q + 16'd1;
			end
		end

		// Saturating offset advance
		if (adv && off_q != '1) off_d = off_q + 1'b1;

		// Mark the final token of this byte
		if (n == 2'd1) res[0].last = 1'b1;
		if (n == 2'd2) res[1].last = 1'b1;
	end

	assign push.cnt  = step ? n : 2'd0;
	assign push.tok0 = res[0];
	assign push.tok1 = res[1];

	// Lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			off_q   <= '0;
			begin_q <= '0;
			line_q  <= 16'd1;
			bline_q <= 16'd1;
			kw_q    <= '0;
		end else if (step) begin
			mode_q  <= mode_d;
			off_q   <= off_d;
			begin_q <= begin_d;
			line_q  <= line_d;
			bline_q <= bline_d;
			kw_q    <= kw_d;
		end
	end

endmodule

// ===== hw/rtl/clx_fifo.sv =====
// Small result queue taking up to two tokens a cycle and giving one when popped.
module clx_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  clx_pkg::push_t push,
	input  logic           pop,
	output logic           room,
	output logic           out_valid,
	output clx_pkg::tok_t  head
);

	clx_pkg::tok_t                mem_q [clx_pkg::FIFO_DEPTH];
	logic [clx_pkg::FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [clx_pkg::FIFO_CW-1:0]  count_q;
	logic [clx_pkg::FIFO_AW-1:0]  wr_ptr_p1;
	logic                         do_pop;

	assign wr_ptr_p1 = wr_ptr_q + 1'b1;
	assign out_valid = (count_q != '0);
	assign do_pop    = pop && out_valid;
	assign room      = (count_q <= clx_pkg::FIFO_CW'(clx_pkg::FIFO_DEPTH - 2));
	assign head      = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) mem_q[wr_ptr_q] <= push.tok0;
		if (push.cnt == 2'd2) mem_q[wr_ptr_p1] <= push.tok1;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + clx_pkg::FIFO_AW'(push.cnt);
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q  <= count_q + clx_pkg::FIFO_CW'(push.cnt) -
				clx_pkg::FIFO_CW'(do_pop);
		end
	end

endmodule

// ===== hw/rtl/c_token_lexer.sv =====
// Top level of the C token lexer: input register, lexer core, result queue.
//
// Usage:
//   s_* channel takes source text, one byte per request in s_tdata; a zero
//   byte ends the text. m_* channel gives tokens, one per request: kind,
//   start offset, length and line packed in m_tdata, and m_tlast high on
//   the last token caused by one input byte (a byte causes zero to two).
// A token appears on m_tvalid once the byte that produced it has passed
//   the input register and a lexer step has written the token into the
//   result queue; the step waits while the queue lacks room.
// Throughput: one byte per cycle while the queue has room. The lexer
//   steps a byte whenever the four-entry result queue has space for two
//   tokens, so bytes flow at full rate while the receiver keeps up; the
//   rate is set by the queue drain, one token per cycle.
// Stall: when the receiver holds m_tready low the queue fills, the lexer
//   stops stepping and s_tready drops once the input register is occupied.
// Reset: arst_n clears the lexer to line 1, offset 0 and empties the queue.
//   A zero byte also returns the lexer to that state after its eof token.
module c_token_lexer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [clx_pkg::IN_TDATA_W-1:0]      s_tdata,  // [7:0] text_char
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [3:0] token_kind, [19:4] token_start, [35:20] token_length,
	// [51:36] token_line, [55:52] zero
	output logic [clx_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                m_tlast   // run_last
);

	logic           valid_s1;
	logic [7:0]     char_s1;
	logic           room;
	logic           step;
	clx_pkg::push_t push;
	clx_pkg::tok_t  head;

	assign step     = valid_s1 && room;
	assign s_tready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) char_s1 <= s_tdata;
	end

	clx_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.text_char (char_s1),
		.push      (push)
	);

	clx_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (m_tready),
		.room      (room),
		.out_valid (m_tvalid),
		.head      (head)
	);

	// Output packing
	assign m_tdata = {4'd0, head.line, head.length, head.start, 4'(head.kind)};
	assign m_tlast = head.last;

endmodule

// ===== hw/rtl/clx_checker.sv =====
// Port-level checks of the C token lexer, bound to the top level.
module clx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tlast
);

	// A stalled token holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_tvalid && !m_tready) |-> $stable(m_tdata) && $stable(m_tlast))
		else $error("token changed while stalled");

	// End of text token has zero length and closes its run
	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3:0] == clx_pkg::KIND_EOF |-> m_tdata[35:20] == 16'd0 && m_tlast)
		else $error("bad eof token");

	// Punctuators are one byte long
	a_punct: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[3:0] == clx_pkg::KIND_LBRACE ||
		m_tdata[3:0] == clx_pkg::KIND_RBRACE || m_tdata[3:0] == clx_pkg::KIND_SEMI ||
		m_tdata[3:0] == clx_pkg::KIND_STAR) |-> m_tdata[35:20] == 16'd1)
		else $error("punctuator length not one");

	// Kind in range, line never zero, padding clear
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] <= clx_pkg::KIND_FLOAT && m_tdata[51:36] != 16'd0 &&
		m_tdata[55:52] == 4'd0)
		else $error("token field out of range");

endmodule

bind c_token_lexer clx_checker u_clx_checker (.*);
